// ===== src/i8mm_pkg.sv =====
// ----------------------------------------------------------------------------
// i8mm_pkg
// Shared types and constants for the int8 tile multiply-accumulate core.
// ----------------------------------------------------------------------------
package i8mm_pkg;

   // Tile geometry and arithmetic widths.
   localparam int TILE_DIM  = 16;
   localparam int BYTE_W    = 8;
   localparam int PROD_W    = 2 * BYTE_W;
   localparam int ACC_W     = 32;
   localparam int ROW_IDX_W = 4;
   localparam int DEF_ROWS  = 16;
   localparam int DEF_COLS  = 16;

   // One slice of signed bytes, element 0 in the low byte.
   typedef logic [TILE_DIM-1:0][BYTE_W-1:0] byte_vec_type;

   // One row of accumulators, column 0 in the low word.
   typedef logic [TILE_DIM-1:0][ACC_W-1:0] sum_vec_type;

   // Input transaction: one contraction step.
   typedef struct packed {
      logic [63:0] a_col_lo;
      logic [63:0] a_col_hi;
      logic [63:0] b_row_lo;
      logic [63:0] b_row_hi;
      logic        first_step;
      logic        last_step;
   } req_type;

   // Result transaction: one row of the finished tile.
   typedef struct packed {
      logic [ROW_IDX_W-1:0] row_index;
      logic [63:0]          sums_01;
      logic [63:0]          sums_23;
      logic [63:0]          sums_45;
      logic [63:0]          sums_67;
      logic [63:0]          sums_89;
      logic [63:0]          sums_1011;
      logic [63:0]          sums_1213;
      logic [63:0]          sums_1415;
      logic                 last_row;
   } rsp_type;

   // Drain sequencer states.
   typedef enum logic {
      DRAIN_IDLE,
      DRAIN_EMIT
   } drain_state_type;

endpackage

// ===== src/i8mm_row_lane.sv =====
// ----------------------------------------------------------------------------
// i8mm_row_lane
// One tile row: a bank of 8x8 signed multipliers, each feeding its own 32-bit
// wrapping accumulator.
// ----------------------------------------------------------------------------
module i8mm_row_lane #(
   parameter int COLS = i8mm_pkg::DEF_COLS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step_valid,
   input  logic                               step_first,
   input  logic signed [i8mm_pkg::BYTE_W-1:0] a_byte,
   input  i8mm_pkg::byte_vec_type             b_bytes,
   output i8mm_pkg::sum_vec_type              sums
);
   import i8mm_pkg::*;

   // One multiply-accumulate cell per used column; unused columns read zero.
   for (genvar c = 0; c < TILE_DIM; c++) begin : g_col
      if (c < COLS) begin : g_used
         logic signed [PROD_W-1:0] prod;
         logic [ACC_W-1:0]         acc_ff;
         logic [ACC_W-1:0]         acc_in;

         assign prod = a_byte * $signed(b_bytes[c]);

         // A first step restarts the sum from zero before adding.
         always_comb begin
            acc_in = acc_ff;
            if (step_valid) begin
               acc_in = (step_first ? '0 : acc_ff)
                      + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               acc_ff <= '0;
            end else begin
               acc_ff <= acc_in;
            end
         end

         assign sums[c] = acc_ff;
      end else begin : g_unused
         assign sums[c] = '0;
      end
   end

endmodule

// ===== src/i8mm_drain.sv =====
// ----------------------------------------------------------------------------
// i8mm_drain
// Merges the row lanes into result transactions: walks the rows in order,
// packs column pairs and holds each row in the output register.
// ----------------------------------------------------------------------------
module i8mm_drain #(
   parameter int ROWS = i8mm_pkg::DEF_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  i8mm_pkg::sum_vec_type row_sums [ROWS],
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output i8mm_pkg::rsp_type     rsp_data,
   output logic                  busy
);
   import i8mm_pkg::*;

   localparam int CNT_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   drain_state_type state_ff;
   drain_state_type state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;
   logic             load_en;
   logic             last_load;
   sum_vec_type      sel;
   rsp_type          packed_row;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         DRAIN_IDLE: begin
            if (start) begin
               state_in = DRAIN_EMIT;
            end
         end
         DRAIN_EMIT: begin
            if (load_en && last_load) begin
               state_in = DRAIN_IDLE;
            end
         end
         default: begin
            state_in = DRAIN_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: load a row whenever the output register frees up.
   always_comb begin
      last_load = (cnt_ff == CNT_W'(ROWS - 1));
      case (state_ff)
         DRAIN_IDLE: begin
            load_en = 1'b0;
         end
         DRAIN_EMIT: begin
            load_en = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            load_en = 1'b0;
         end
      endcase
   end

   // Row select and column pair packing.
   always_comb begin
      sel                  = row_sums[cnt_ff];
      packed_row.row_index = ROW_IDX_W'(cnt_ff);
      packed_row.sums_01   = {sel[1],  sel[0]};
      packed_row.sums_23   = {sel[3],  sel[2]};
      packed_row.sums_45   = {sel[5],  sel[4]};
      packed_row.sums_67   = {sel[7],  sel[6]};
      packed_row.sums_89   = {sel[9],  sel[8]};
      packed_row.sums_1011 = {sel[11], sel[10]};
      packed_row.sums_1213 = {sel[13], sel[12]};
      packed_row.sums_1415 = {sel[15], sel[14]};
      packed_row.last_row  = last_load;
   end

   // Row counter and output register.
   always_comb begin
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (start) begin
         cnt_in = '0;
      end else if (load_en) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (load_en) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = packed_row;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DRAIN_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign busy      = (state_ff == DRAIN_EMIT);

endmodule

// ===== src/int8_tile_matmul_accumulate_core.sv =====
// ----------------------------------------------------------------------------
// int8_tile_matmul_accumulate_core: int8 x int8 tile product, int32 sums.
// Accepts one contraction step per cycle, unless held off, into a ROWS x COLS
// multiplier array. A last step's rows leave the output register, row 0 first,
// one per cycle while rsp_ready is high; input waits until the last is loaded.
// Synchronous reset clears all accumulators and empties the output register.
// ----------------------------------------------------------------------------
module int8_tile_matmul_accumulate_core #(
   parameter int ROWS = i8mm_pkg::DEF_ROWS,
   parameter int COLS = i8mm_pkg::DEF_COLS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  i8mm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output i8mm_pkg::rsp_type rsp_data
);
   import i8mm_pkg::*;

   logic         stage_valid_ff;
   logic         stage_valid_in;
   byte_vec_type stage_a_ff;
   byte_vec_type stage_b_ff;
   logic         stage_first_ff;
   logic         stage_last_ff;
   logic         req_accept;
   logic         drain_start;
   logic         drain_busy;
   sum_vec_type  row_sums [ROWS];

   // Input is held off while a tile is being emitted or about to be.
   assign req_ready   = !drain_busy && !(stage_valid_ff && stage_last_ff);
   assign req_accept  = req_valid && req_ready;
   assign drain_start = stage_valid_ff && stage_last_ff;

   // Step register in front of the multiplier array.
   assign stage_valid_in = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_a_ff     <= {req_data.a_col_hi, req_data.a_col_lo};
         stage_b_ff     <= {req_data.b_row_hi, req_data.b_row_lo};
         stage_first_ff <= req_data.first_step;
         stage_last_ff  <= req_data.last_step;
      end
   end

   // One lane per tile row, all updating in the same cycle.
   for (genvar r = 0; r < ROWS; r++) begin : g_row
      i8mm_row_lane #(
         .COLS (COLS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .step_valid (stage_valid_ff),
         .step_first (stage_first_ff),
         .a_byte     ($signed(stage_a_ff[r])),
         .b_bytes    (stage_b_ff),
         .sums       (row_sums[r])
      );
   end

   // Row walker and output register.
   i8mm_drain #(
      .ROWS (ROWS)
   ) u_drain (
      .clock     (clock),
      .reset     (reset),
      .start     (drain_start),
      .row_sums  (row_sums),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .busy      (drain_busy)
   );

`ifndef SYNTHESIS
   // No step may reach the array while rows are being read out.
   a_no_accept_while_draining: assert property (@(posedge clock) disable iff (reset)
      drain_busy |-> !req_ready)
      else $error("step accepted while tile drains");

   // A last step in the step register starts the drain on the next cycle.
   a_last_starts_drain: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && stage_last_ff) |=> drain_busy)
      else $error("last step did not start the drain");

   // The last-row flag marks exactly the final tile row.
   a_last_row_marks_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_row == (rsp_data.row_index == ROW_IDX_W'(ROWS - 1))))
      else $error("last_row flag does not match row index");
`endif

endmodule

// ===== dv/tile_product_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_product_checker
// Watches both channels of the int8 tile multiply-accumulate core. It keeps
// its own copy of the 16 x 16 int32 tile and builds the expected rows for
// every last step. Each accepted row is then compared field by field with the
// oldest row still waiting.
// ----------------------------------------------------------------------------
module tile_product_checker #(
   parameter int ROWS = i8mm_pkg::DEF_ROWS,
   parameter int COLS = i8mm_pkg::DEF_COLS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  i8mm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  i8mm_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                rows_pending,
   output int                rows_checked
);
   import i8mm_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // Predicted tile and the finished rows that have not been seen yet.
   logic [ACC_W-1:0] tile_sums [TILE_DIM][TILE_DIM];
   rsp_type          rows_due[$];

   // Clears the predicted tile.
   task automatic clear_tile();
      for (int r = 0; r < TILE_DIM; r++)
         for (int c = 0; c < TILE_DIM; c++)
            tile_sums[r][c] = '0;
   endtask

   // Adds one contraction step to the tile and queues the rows of a last step.
   task automatic add_step(input req_type step);
      byte_vec_type             a_bytes;
      byte_vec_type             b_bytes;
      logic signed [BYTE_W-1:0] a_val;
      logic signed [BYTE_W-1:0] b_val;
      int                       product;
      sum_vec_type              row_sums;
      rsp_type                  row_out;
      a_bytes = {step.a_col_hi, step.a_col_lo};
      b_bytes = {step.b_row_hi, step.b_row_lo};
      if (step.first_step) begin
         clear_tile();
      end
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            a_val   = a_bytes[r];
            b_val   = b_bytes[c];
            product = a_val * b_val;
            tile_sums[r][c] = tile_sums[r][c] + product;
         end
      end
      if (step.last_step) begin
         for (int r = 0; r < ROWS; r++) begin
            // Columns outside the tile read as zero.
            row_sums = '0;
            for (int c = 0; c < COLS; c++)
               row_sums[c] = tile_sums[r][c];
            row_out.row_index = ROW_IDX_W'(r);
            row_out.sums_01   = row_sums[1:0];
            row_out.sums_23   = row_sums[3:2];
            row_out.sums_45   = row_sums[5:4];
            row_out.sums_67   = row_sums[7:6];
            row_out.sums_89   = row_sums[9:8];
            row_out.sums_1011 = row_sums[11:10];
            row_out.sums_1213 = row_sums[13:12];
            row_out.sums_1415 = row_sums[15:14];
            row_out.last_row  = (r == ROWS - 1);
            rows_due.push_back(row_out);
         end
      end
   endtask

   // Counts a wrong field and reports the first few.
   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] seen, input int row);
      if (want !== seen) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("%0t: row %0d field %s: expected %h, got %h",
                     $realtime, row, name, want, seen);
         end
      end
   endtask

   // Compares one accepted row with the oldest expected row.
   task automatic check_row(input rsp_type seen);
      rsp_type want;
      int      row;
      if (rows_due.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected row %0d with no finished tile pending",
                     $realtime, seen.row_index);
         end
      end else begin
         want = rows_due.pop_front();
         row  = int'(want.row_index);
         rows_checked++;
         check_field("row_index", 64'(want.row_index), 64'(seen.row_index), row);
         check_field("sums_01", want.sums_01, seen.sums_01, row);
         check_field("sums_23", want.sums_23, seen.sums_23, row);
         check_field("sums_45", want.sums_45, seen.sums_45, row);
         check_field("sums_67", want.sums_67, seen.sums_67, row);
         check_field("sums_89", want.sums_89, seen.sums_89, row);
         check_field("sums_1011", want.sums_1011, seen.sums_1011, row);
         check_field("sums_1213", want.sums_1213, seen.sums_1213, row);
         check_field("sums_1415", want.sums_1415, seen.sums_1415, row);
         check_field("last_row", 64'(want.last_row), 64'(seen.last_row), row);
      end
   endtask

   // Samples both channels on every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_tile();
         rows_due.delete();
         error_count  = 0;
         rows_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_row(rsp_data);
         end
         if (req_valid && req_ready) begin
            add_step(req_data);
         end
      end
      rows_pending = rows_due.size();
   end

endmodule

// ===== dv/int8_tile_matmul_accumulate_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int8_tile_matmul_accumulate_core_test
// Drives contraction steps into the int8 tile core and stalls its result
// channel at random. A short directed part hits byte extremes and every flag
// combination, a steady run without gaps piles up the largest products of
// both signs, and random tiles with some broken flag sequences follow.
// Checking is done by tile_product_checker.
// ----------------------------------------------------------------------------
module int8_tile_matmul_accumulate_core_test;
   import i8mm_pkg::*;

   localparam int IDLE_PERCENT   = 29;
   localparam int RANDOM_STEPS   = 156;
   localparam int WRAP_STEPS     = 15;
   localparam int STALL_LIMIT    = 1000;
   localparam int SETTLE_CYCLES  = 24;
   localparam logic [63:0] ALL_MIN  = 64'h8080_8080_8080_8080;
   localparam logic [63:0] ALL_MAX  = 64'h7F7F_7F7F_7F7F_7F7F;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_data    = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_data;

   int error_count;
   int rows_pending;
   int rows_checked;
   int steps_sent    = 0;
   int tiles_closed  = 0;
   int idle_cycles   = 0;
   bit steady_flow   = 1'b0;

   int8_tile_matmul_accumulate_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   tile_product_checker i_tile_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .error_count  (error_count),
      .rows_pending (rows_pending),
      .rows_checked (rows_checked)
   );

   // Free-running clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The result side stalls at random except during steady stretches.
   always @(posedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Ends the run when neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d rows still due",
                  idle_cycles, rows_pending);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Builds one step from its four byte slices and two flags.
   function automatic req_type make_step(input logic [63:0] a_lo, input logic [63:0] a_hi,
                                         input logic [63:0] b_lo, input logic [63:0] b_hi,
                                         input logic first, input logic last);
      req_type step;
      step.a_col_lo   = a_lo;
      step.a_col_hi   = a_hi;
      step.b_row_lo   = b_lo;
      step.b_row_hi   = b_hi;
      step.first_step = first;
      step.last_step  = last;
      return step;
   endfunction

   // Random slice of eight bytes, with the byte extremes mixed in often.
   function automatic logic [63:0] random_slice();
      logic [63:0] word;
      word = {$urandom, $urandom};
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(7))
            0: word[i*8 +: 8] = 8'h80;
            1: word[i*8 +: 8] = 8'h7F;
            2: word[i*8 +: 8] = 8'h00;
            3: word[i*8 +: 8] = 8'hFF;
            default: ;
         endcase
      end
      return word;
   endfunction

   // Offers one step, entered and left on a rising edge.
   task automatic send_step(input req_type step);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= step;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      steps_sent++;
      if (step.last_step) tiles_closed++;
   endtask

   // Holds the sender off until every finished row has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (rows_pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Stimulus and verdict.
   initial begin
      req_type step;
      int      tile_len;
      int      sent;
      logic    first;
      logic    last;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a last step right after reset adds onto the reset value.
      send_step(make_step(ALL_MAX, ALL_MAX, ALL_MIN, ALL_MIN, 1'b0, 1'b1));
      // Both flags with the largest product.
      send_step(make_step(ALL_MIN, ALL_MIN, ALL_MIN, ALL_MIN, 1'b1, 1'b1));
      // No first step: adds onto the tile that was just emitted.
      send_step(make_step(64'h0807_0605_0403_0201, 64'h100F_0E0D_0C0B_0A09,
                          64'hF8F9_FAFB_FCFD_FEFF, 64'hF0F1_F2F3_F4F5_F6F7, 1'b0, 1'b1));
      // A three step tile with a step that carries neither flag.
      send_step(make_step(ALL_ONES, ALL_ONES, 64'h0101_0101_0101_0101,
                          64'h0101_0101_0101_0101, 1'b1, 1'b0));
      send_step(make_step(ALL_MAX, ALL_MIN, ALL_MAX, ALL_MIN, 1'b0, 1'b0));
      send_step(make_step(ALL_MIN, ALL_MAX, ALL_MAX, ALL_MAX, 1'b0, 1'b1));
      // All-zero and all-ones bytes.
      send_step(make_step('0, '0, '0, '0, 1'b1, 1'b1));
      send_step(make_step(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, 1'b1));
      // A first step in the middle of a tile throws away what came before.
      send_step(make_step(ALL_MAX, ALL_MAX, ALL_MAX, ALL_MAX, 1'b1, 1'b0));
      send_step(make_step(64'h807F_00FF_0180_7F01, 64'hFF00_7F80_01FF_807F,
                          64'h0180_7FFF_0080_7F01, 64'h7F80_FF01_007F_80FF, 1'b1, 1'b1));
      wait_drained();

      // A steady run with no idling: even rows climb, odd rows fall.
      steady_flow = 1'b1;
      send_step(make_step(64'h7F80_7F80_7F80_7F80, 64'h7F80_7F80_7F80_7F80,
                          ALL_MIN, ALL_MIN, 1'b1, 1'b0));
      for (int i = 0; i < WRAP_STEPS; i++) begin
         send_step(make_step(64'h7F80_7F80_7F80_7F80, 64'h7F80_7F80_7F80_7F80,
                             ALL_MIN, ALL_MIN, 1'b0, (i == WRAP_STEPS - 1)));
      end
      steady_flow = 1'b0;
      wait_drained();

      // Random tiles, mostly well formed, some with scrambled flags.
      sent = 0;
      while (sent < RANDOM_STEPS) begin
         tile_len = $urandom_range(6, 1);
         for (int k = 0; k < tile_len; k++) begin
            first = (k == 0);
            last  = (k == tile_len - 1);
            if ($urandom_range(99) < 10) begin
               first = 1'($urandom_range(1));
               last  = 1'($urandom_range(1));
            end
            step = make_step(random_slice(), random_slice(), random_slice(),
                             random_slice(), first, last);
            steady_flow = (sent >= 60 && sent < 100);
            if (sent == 120) wait_drained();
            send_step(step);
            sent++;
         end
      end
      steady_flow = 1'b0;

      // Let the last tile drain, then allow a little slack for stray rows.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d contraction steps closing %0d tiles, %0d in one steady run.",
               steps_sent, tiles_closed, WRAP_STEPS + 1);
      $display("%0d result rows compared, %0d errors, %0d rows left over.",
               rows_checked, error_count, rows_pending);
      if (error_count == 0 && rows_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/i8mm_pkg.sv
src/i8mm_row_lane.sv
src/i8mm_drain.sv
src/int8_tile_matmul_accumulate_core.sv
dv/tile_product_checker.sv
dv/int8_tile_matmul_accumulate_core_test.sv
